>>> rtl/rzcq_pkg.sv
// Shared types, constants and lookup functions of the ranging zone qualifier.
`timescale 1ns / 1ps
package rzcq_pkg;

  localparam int PROB_BITS = 16;
  localparam int PROB_W    = PROB_BITS + 1;

  localparam logic [1:0] ZONE_UNKNOWN = 2'd0;
  localparam logic [1:0] ZONE_NEAR    = 2'd1;
  localparam logic [1:0] ZONE_FAR     = 2'd2;

  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_HYSTERESIS = 2'd1;
  localparam logic [1:0] REG_CONF_MIN   = 2'd2;
  localparam logic [1:0] REG_RUN_LENGTH = 2'd3;

  localparam logic [24:0] Q_ONE  = 25'd16777216;
  localparam logic [22:0] K_P    = 23'd5496067;
  localparam logic [27:0] K_A1   = 28'd4275331;
  localparam logic [27:0] K_A2   = 28'd4773063;
  localparam logic [27:0] K_A3   = 28'd23847365;
  localparam logic [27:0] K_A4   = 28'd24379845;
  localparam logic [27:0] K_A5   = 28'd17807428;
  localparam logic [23:0] K_RS2  = 24'd11863283;
  localparam logic [23:0] K_LN2  = 24'd11629080;
  localparam logic [27:0] Z_SAT  = 28'h6000000;
  localparam logic [26:0] X_BIG  = 27'h4000000;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_PREP, OP_SQRT, OP_DIVZ_INIT, OP_DIVZ, OP_MULX, OP_MULP,
    OP_DIVT, OP_POLY, OP_MULY, OP_RED, OP_EXPA, OP_EXPB, OP_SHIFT, OP_PE,
    OP_CDF, OP_DECIDE
  } op_e;

  typedef struct packed {
    op_e op;
  } rzcq_cmd_t;

  typedef struct packed {
    logic var_zero;
    logic cnt_zero;
    logic x_large;
    logic r_ge_ln2;
    logic k_last;
    logic out_busy;
  } rzcq_stat_t;

  // Horner addend for the erf polynomial, selected by the step counter
  function automatic logic signed [27:0] poly_coef(input logic [4:0] idx);
    logic signed [27:0] c;
    case (idx)
      5'd4:    c = -$signed(K_A4);
      5'd3:    c =  $signed(K_A3);
      5'd2:    c = -$signed(K_A2);
      5'd1:    c =  $signed(K_A1);
      default: c = 28'sd0;
    endcase
    return c;
  endfunction

  // Reciprocal multiplier for an exact floor(v / k), v below 2^24
  function automatic logic [24:0] recip_mul(input logic [3:0] k);
    logic [24:0] m;
    case (k)
      4'd3:    m = 25'd22369622;
      4'd5:    m = 25'd26843546;
      4'd6:    m = 25'd22369622;
      4'd7:    m = 25'd19173962;
      default: m = 25'd16777217;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] recip_shift(input logic [3:0] k);
    logic [4:0] s;
    case (k)
      4'd1:    s = 5'd24;
      4'd2:    s = 5'd25;
      4'd3:    s = 5'd26;
      4'd4:    s = 5'd26;
      default: s = 5'd27;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/ranging_zone_confidence_qualifier.sv
// Top level of the ranging zone qualifier: sequencer plus datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel: distance_mean_i / distance_variance_i with in_valid_i and
//   in_stall_o. An item is taken at a clock edge with valid high and stall low.
//   Output channel: zone_o with out_valid_o and out_stall_i; one zone item
//   per input item, in order. zone_o holds while out_stall_i is high.
//   Configuration: cfg_we_i writes cfg_data_i into the register picked by
//   cfg_idx_i (0 threshold, 1 hysteresis, 2 confidence minimum, 3 run length).
//   Write only while the block is idle.
// Sequence:
//   One item at a time: the next item is taken only after the zone of the
//   current one has been loaded. A zero variance item goes straight to the
//   decision; when the erf argument reaches 4.0 it takes a 24-step square
//   root, then a 28-step divide, or 1 step when it saturates; else it adds
//   a 25-step divide, 5 Horner steps, 1 to 24 range reduction steps and the
//   exp evaluation steps, all on shared units. A stalled output holds only
//   the final step until the register frees.
// Reset: clears zone state, counters and the output valid, and loads the
//   register defaults (threshold 2.0 m, hysteresis 0.5 m, 0.9, run length 3).
module ranging_zone_confidence_qualifier
  import rzcq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [19:0] distance_mean_i,
  input  logic [31:0]        distance_variance_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         zone_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [19:0]        cfg_data_i
);

  rzcq_cmd_t  cmd;
  rzcq_stat_t stat;

  // sequence the item through the datapath steps
  rzcq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic, configuration registers, zone state and output register
  rzcq_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .distance_mean_i     (distance_mean_i),
    .distance_variance_i (distance_variance_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .zone_o              (zone_o)
  );

endmodule

>>> rtl/rzcq_ctrl.sv
// Sequencer of the zone qualifier: walks one item through the datapath steps.
`timescale 1ns / 1ps
module rzcq_ctrl
  import rzcq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  rzcq_stat_t stat_i,
  output rzcq_cmd_t  cmd_o
);

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_PREP      = 17'h00002,
    S_SQRT      = 17'h00004,
    S_DIVZ_INIT = 17'h00008,
    S_DIVZ      = 17'h00010,
    S_MULX      = 17'h00020,
    S_MULP      = 17'h00040,
    S_DIVT      = 17'h00080,
    S_POLY      = 17'h00100,
    S_MULY      = 17'h00200,
    S_RED       = 17'h00400,
    S_EXPA      = 17'h00800,
    S_EXPB      = 17'h01000,
    S_SHIFT     = 17'h02000,
    S_PE        = 17'h04000,
    S_CDF       = 17'h08000,
    S_DECIDE    = 17'h10000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.op = OP_PREP;
        state_d  = stat_i.var_zero ? S_DECIDE : S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (stat_i.cnt_zero) state_d = S_DIVZ_INIT;
      end
      S_DIVZ_INIT: begin
        cmd_o.op = OP_DIVZ_INIT;
        state_d  = S_DIVZ;
      end
      S_DIVZ: begin
        cmd_o.op = OP_DIVZ;
        if (stat_i.cnt_zero) state_d = S_MULX;
      end
      S_MULX: begin
        cmd_o.op = OP_MULX;
        state_d  = S_MULP;
      end
      S_MULP: begin
        cmd_o.op = OP_MULP;
        state_d  = stat_i.x_large ? S_CDF : S_DIVT;
      end
      S_DIVT: begin
        cmd_o.op = OP_DIVT;
        if (stat_i.cnt_zero) state_d = S_POLY;
      end
      S_POLY: begin
        cmd_o.op = OP_POLY;
        if (stat_i.cnt_zero) state_d = S_MULY;
      end
      S_MULY: begin
        cmd_o.op = OP_MULY;
        state_d  = S_RED;
      end
      S_RED: begin
        cmd_o.op = OP_RED;
        if (!stat_i.r_ge_ln2) state_d = S_EXPA;
      end
      S_EXPA: begin
        cmd_o.op = OP_EXPA;
        state_d  = S_EXPB;
      end
      S_EXPB: begin
        cmd_o.op = OP_EXPB;
        state_d  = stat_i.k_last ? S_SHIFT : S_EXPA;
      end
      S_SHIFT: begin
        cmd_o.op = OP_SHIFT;
        state_d  = S_PE;
      end
      S_PE: begin
        cmd_o.op = OP_PE;
        state_d  = S_CDF;
      end
      S_CDF: begin
        cmd_o.op = OP_CDF;
        state_d  = S_DECIDE;
      end
      S_DECIDE: begin
        // hold until the output register is free
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_DECIDE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/rzcq_dp.sv
// Datapath of the zone qualifier: registers, iterative sqrt/divide, multiplies, zone state.
`timescale 1ns / 1ps
module rzcq_dp
  import rzcq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rzcq_cmd_t          cmd_i,
  output rzcq_stat_t         stat_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [19:0]        cfg_data_i,
  input  logic signed [19:0] distance_mean_i,
  input  logic [31:0]        distance_variance_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         zone_o
);

  logic signed [19:0] thr_q;
  logic [18:0]        hyst_q;
  logic [16:0]        cmin_q;
  logic [7:0]         rrl_q;

  logic signed [19:0] mean_q;
  logic [31:0]        var_q;
  logic               d_neg_q;
  logic [20:0]        ad_q;
  logic [4:0]         cnt_q;
  logic [47:0]        sq_v_q;
  logic [25:0]        sq_rem_q;
  logic [23:0]        root_q;
  logic [25:0]        dv_rem_q, dv_dvs_q;
  logic [27:0]        quo_q;
  logic [26:0]        x_q;
  logic signed [27:0] pacc_q;
  logic [27:0]        r_q;
  logic [4:0]         n_q;
  logic [24:0]        eacc_q;
  logic [23:0]        eprod_q;
  logic [3:0]         k_q;
  logic [24:0]        e_q;
  logic [24:0]        erf_q;
  logic [PROB_W-1:0]  pnear_q;
  logic [1:0]         present_q, pending_q;
  logic [7:0]         agree_q;
  logic               out_valid_q;
  logic [1:0]         zone_q;

  logic signed [21:0] bound, d;
  logic [27:0]        sq_t, sq_trial;
  logic [26:0]        dv_t;
  logic [27:0]        zsat;
  logic [50:0]        x_prod;
  logic [49:0]        kp_prod;
  logic signed [53:0] p_prod;
  logic signed [53:0] p_trunc;
  logic [53:0]        y_prod;
  logic [48:0]        ea_prod;
  logic [48:0]        eb_prod;
  logic [48:0]        eb_quot;
  logic [26:0]        poly_pos;
  logic [51:0]        pe_prod;
  logic [25:0]        cdf_sum;
  logic [24:0]        cdf;
  logic [24+PROB_BITS:0] pn_sum;
  logic [PROB_W-1:0]  pfar;
  logic [1:0]         proposed;
  logic [7:0]         agree_inc;

  assign stat_o.var_zero = (var_q == 32'd0);
  assign stat_o.cnt_zero = (cnt_q == 5'd0);
  assign stat_o.x_large  = (x_q >= X_BIG);
  assign stat_o.r_ge_ln2 = (r_q >= {4'd0, K_LN2});
  assign stat_o.k_last   = (k_q == 4'd1);
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign zone_o      = zone_q;

  always_comb begin
    bound = 22'(thr_q);
    case (present_q)
      ZONE_NEAR: bound = bound + $signed({3'd0, hyst_q});
      ZONE_FAR:  bound = bound - $signed({3'd0, hyst_q});
      default:   bound = 22'(thr_q);
    endcase
    d = bound - 22'(mean_q);

    sq_t     = {sq_rem_q, sq_v_q[47:46]};
    sq_trial = {2'd0, root_q, 2'b01};
    dv_t     = {dv_rem_q, 1'b0};

    zsat    = (quo_q > Z_SAT) ? Z_SAT : quo_q;
    x_prod  = 51'(zsat) * 51'(K_RS2);
    kp_prod = 50'(K_P) * 50'(x_q);

    p_prod  = 54'(pacc_q) * $signed({28'd0, quo_q[24:0]});
    p_trunc = (p_prod < 0) ? ((p_prod + 54'sd16777215) >>> 24) : (p_prod >>> 24);

    y_prod  = 54'(x_q) * 54'(x_q);
    ea_prod = 49'(r_q[23:0]) * 49'(eacc_q);
    eb_prod = 49'(eprod_q) * 49'(recip_mul(k_q));
    eb_quot = eb_prod >> recip_shift(k_q);

    poly_pos = pacc_q[27] ? 27'd0 : pacc_q[26:0];
    pe_prod  = 52'(poly_pos) * 52'(e_q);

    cdf_sum = d_neg_q ? (26'(Q_ONE) - 26'(erf_q)) : (26'(Q_ONE) + 26'(erf_q));
    cdf     = cdf_sum[25:1];
    pn_sum  = {cdf, {PROB_BITS{1'b0}}} + (25'(1) << 23);

    pfar = (PROB_W'(1) << PROB_BITS) - pnear_q;
    if (pnear_q >= cmin_q)     proposed = ZONE_NEAR;
    else if (pfar >= cmin_q)   proposed = ZONE_FAR;
    else                       proposed = present_q;
    agree_inc = (agree_q == 8'd255) ? agree_q : agree_q + 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= 20'sd512;
      hyst_q      <= 19'd128;
      cmin_q      <= 17'd58982;
      rrl_q       <= 8'd3;
      present_q   <= ZONE_UNKNOWN;
      pending_q   <= ZONE_UNKNOWN;
      agree_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD:  thr_q  <= $signed(cfg_data_i);
          REG_HYSTERESIS: hyst_q <= cfg_data_i[18:0];
          REG_CONF_MIN:   cmin_q <= cfg_data_i[16:0];
          REG_RUN_LENGTH: rrl_q  <= cfg_data_i[7:0];
          default:        thr_q  <= thr_q;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.op == OP_DECIDE) begin
        out_valid_q <= 1'b1;
        if (proposed != present_q) begin
          if (proposed == pending_q) begin
            if (agree_inc >= rrl_q) begin
              present_q <= proposed;
              pending_q <= ZONE_UNKNOWN;
              agree_q   <= 8'd0;
            end else begin
              agree_q   <= agree_inc;
            end
          end else begin
            if (8'd1 >= rrl_q) begin
              present_q <= proposed;
              pending_q <= ZONE_UNKNOWN;
              agree_q   <= 8'd0;
            end else begin
              pending_q <= proposed;
              agree_q   <= 8'd1;
            end
          end
        end else begin
          pending_q <= ZONE_UNKNOWN;
          agree_q   <= 8'd0;
        end
      end
    end
  end

  // Zone result register loads with the state it reports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DECIDE) begin
      if (proposed != present_q &&
          ((proposed == pending_q && agree_inc >= rrl_q) ||
           (proposed != pending_q && 8'd1 >= rrl_q))) begin
        zone_q <= proposed;
      end else begin
        zone_q <= present_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mean_q <= distance_mean_i;
        var_q  <= distance_variance_i;
      end
      OP_PREP: begin
        d_neg_q  <= d[21];
        ad_q     <= d[21] ? 21'(-d) : d[20:0];
        pnear_q  <= d[21] ? '0 : (PROB_W'(1) << PROB_BITS);
        sq_v_q   <= {var_q, 16'd0};
        sq_rem_q <= '0;
        root_q   <= '0;
        cnt_q    <= 5'd23;
      end
      OP_SQRT: begin
        if (sq_t >= sq_trial) begin
          sq_rem_q <= 26'(sq_t - sq_trial);
          root_q   <= {root_q[22:0], 1'b1};
        end else begin
          sq_rem_q <= sq_t[25:0];
          root_q   <= {root_q[22:0], 1'b0};
        end
        sq_v_q <= {sq_v_q[45:0], 2'd0};
        cnt_q  <= cnt_q - 5'd1;
      end
      OP_DIVZ_INIT: begin
        // quotient would exceed the saturation point: skip the divide
        if ({ad_q, 4'd0} >= {1'b0, root_q}) begin
          quo_q <= Z_SAT;
          cnt_q <= 5'd0;
        end else begin
          quo_q <= '0;
          cnt_q <= 5'd27;
        end
        dv_rem_q <= {1'b0, ad_q, 4'd0};
        dv_dvs_q <= {2'd0, root_q};
      end
      OP_DIVZ, OP_DIVT: begin
        if (!(cmd_i.op == OP_DIVZ && quo_q == Z_SAT && dv_dvs_q <= {1'b0, dv_rem_q[24:0]}))
        begin
          if (dv_t >= {1'b0, dv_dvs_q}) begin
            dv_rem_q <= 26'(dv_t - {1'b0, dv_dvs_q});
            quo_q    <= {quo_q[26:0], 1'b1};
          end else begin
            dv_rem_q <= dv_t[25:0];
            quo_q    <= {quo_q[26:0], 1'b0};
          end
        end
        if (cmd_i.op == OP_DIVT && cnt_q == 5'd0) begin
          pacc_q <= $signed(K_A5);
          cnt_q  <= 5'd4;
        end else if (cnt_q != 5'd0) begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
      OP_MULX: begin
        x_q <= x_prod[50:24];
      end
      OP_MULP: begin
        erf_q    <= Q_ONE;
        dv_rem_q <= 26'd8388608;
        dv_dvs_q <= 26'(Q_ONE) + kp_prod[49:24];
        quo_q    <= '0;
        cnt_q    <= 5'd24;
      end
      OP_POLY: begin
        pacc_q <= p_trunc[27:0] + poly_coef(cnt_q);
        cnt_q  <= cnt_q - 5'd1;
      end
      OP_MULY: begin
        r_q <= y_prod[51:24];
        n_q <= '0;
      end
      OP_RED: begin
        if (r_q >= {4'd0, K_LN2}) begin
          r_q <= r_q - {4'd0, K_LN2};
          n_q <= n_q + 5'd1;
        end else begin
          eacc_q <= Q_ONE;
          k_q    <= 4'd8;
        end
      end
      OP_EXPA: begin
        eprod_q <= ea_prod[47:24];
      end
      OP_EXPB: begin
        eacc_q <= Q_ONE - 25'(eb_quot);
        k_q    <= k_q - 4'd1;
      end
      OP_SHIFT: begin
        e_q <= eacc_q >> n_q;
      end
      OP_PE: begin
        erf_q <= (pe_prod[51:24] > 28'(Q_ONE)) ? 25'd0 : Q_ONE - pe_prod[48:24];
      end
      OP_CDF: begin
        pnear_q <= pn_sum[24+PROB_BITS:24];
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

endmodule
